### hdl/tws_pkg.sv
`default_nettype none
package tws_pkg;

  // command bytes sent to the sensor
  localparam logic [7:0] CMD_HUMIDITY    = 8'h05;
  localparam logic [7:0] CMD_TEMPERATURE = 8'h03;
  localparam logic [7:0] CMD_NONE        = 8'h00;

  // connection reset gives this many clock pulses
  localparam logic [3:0] RESET_PULSES = 4'd9;
  // last step index of the start pattern
  localparam logic [3:0] START_LAST = 4'd6;
  localparam logic [15:0] WAIT_LIMIT_RESET = 16'hFFFF;
  localparam logic [15:0] WAIT_COUNT_MAX   = 16'hFFFF;
  localparam logic [1:0]  FAULT_MAX        = 2'd3;

  // register map
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic CFG_IDX_WAIT_LIMIT = 1'b0;

  // operation codes on the input word
  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_HUMIDITY = 2'd1,
    OP_TEMP     = 2'd2,
    OP_CONN_RST = 2'd3
  } op_t;

  typedef enum logic [5:0] {
    PH_IDLE    = 6'd0,
    PH_RST_HI  = 6'd1,
    PH_RST_LO  = 6'd2,
    PH_START   = 6'd3,
    PH_WR_SET  = 6'd4,
    PH_WR_HI   = 6'd5,
    PH_WR_LO   = 6'd6,
    PH_ACK_REL = 6'd7,
    PH_ACK_HI  = 6'd8,
    PH_ACK_LO  = 6'd9,
    PH_WAIT    = 6'd10,
    PH_RD_REL  = 6'd11,
    PH_RD_HI   = 6'd12,
    PH_RD_LO   = 6'd13,
    PH_RA_SET  = 6'd14,
    PH_RA_HI   = 6'd15,
    PH_RA_LO   = 6'd16,
    PH_RA_REL  = 6'd17
  } phase_t;

  // bus master state carried from word to word
  typedef struct packed {
    phase_t      phase;
    logic [3:0]  bit_index;
    logic [1:0]  byte_index;
    logic [7:0]  shift_reg;
    logic [15:0] value_store;
    logic [7:0]  checksum_store;
    logic [15:0] wait_count;
    logic [1:0]  fault_store;
    logic [7:0]  command_byte;
    logic        sck;
    logic        sda;
  } state_t;

  // apb request side
  typedef struct packed {
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
  } apb_req_t;

endpackage
`default_nettype wire

### hdl/tws_if.sv
`default_nettype none
interface tws_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic       data_line;

  modport source (output valid, output op, output data_line, input ready);
  modport sink   (input valid, input op, input data_line, output ready);
endinterface

interface tws_out_if;
  logic        valid;
  logic        ready;
  logic        sck_level;
  logic        data_level;
  logic        busy_res;
  logic        finished;
  logic [15:0] raw_value;
  logic [7:0]  check_byte;
  logic [1:0]  fault_count;

  modport source (output valid, output sck_level, output data_level, output busy_res,
                  output finished, output raw_value, output check_byte,
                  output fault_count, input ready);
  modport sink   (input valid, input sck_level, input data_level, input busy_res,
                  input finished, input raw_value, input check_byte,
                  input fault_count, output ready);
endinterface
`default_nettype wire

### hdl/tws_cfg.sv
`default_nettype none
module tws_cfg (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire tws_pkg::apb_req_t req,
  output logic [31:0]          prdata,
  output logic [15:0]          wait_limit
);
  import tws_pkg::*;

  logic [15:0] wait_limit_r;
  logic        wr_en;
  logic        sel_wait;

  assign sel_wait = (req.paddr[CFG_ADDR_W-1] == CFG_IDX_WAIT_LIMIT);
  assign wr_en    = req.psel && req.penable && req.pwrite;

  // register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_limit_r <= WAIT_LIMIT_RESET;
    end else if (wr_en && sel_wait) begin
      wait_limit_r <= req.pwdata[15:0];
    end
  end

  // read mux
  always_comb begin
    prdata = 32'd0;
    if (sel_wait) begin
      prdata = {16'd0, wait_limit_r};
    end
  end

  assign wait_limit = wait_limit_r;
endmodule
`default_nettype wire

### hdl/tws_step.sv
`default_nettype none
module tws_step (
  input  wire tws_pkg::state_t cur,
  input  wire logic [1:0]      op,
  input  wire logic            din,
  input  wire logic [15:0]     wait_limit,
  output tws_pkg::state_t      nxt,
  output logic                 done
);
  import tws_pkg::*;

  logic [15:0] wait_inc;
  logic [1:0]  fault_inc;
  logic [3:0]  rst_cnt;

  // saturating counters
  assign wait_inc  = (cur.wait_count != WAIT_COUNT_MAX) ? cur.wait_count + 16'd1
                                                        : cur.wait_count;
  assign fault_inc = (cur.fault_store != FAULT_MAX) ? cur.fault_store + 2'd1
                                                     : cur.fault_store;
  assign rst_cnt   = cur.bit_index + 4'd1;

  // one pin step
  always_comb begin
    nxt  = cur;
    done = 1'b0;
    unique case (cur.phase)
      PH_IDLE: begin
        if (op != OP_TICK) begin
          nxt.sck       = 1'b0;
          nxt.sda       = 1'b1;
          nxt.bit_index = 4'd0;
          if (op == OP_CONN_RST) begin
            nxt.command_byte = CMD_NONE;
            nxt.phase        = PH_RST_HI;
          end else begin
            nxt.command_byte = (op == OP_HUMIDITY) ? CMD_HUMIDITY : CMD_TEMPERATURE;
            nxt.fault_store  = 2'd0;
            nxt.phase        = PH_START;
            nxt.bit_index    = 4'd1;
          end
        end
      end
      PH_RST_HI: begin
        nxt.sck   = 1'b1;
        nxt.phase = PH_RST_LO;
      end
      PH_RST_LO: begin
        nxt.sck = 1'b0;
        if (rst_cnt >= RESET_PULSES) begin
          nxt.bit_index = 4'd0;
          nxt.phase     = PH_START;
        end else begin
          nxt.bit_index = rst_cnt;
          nxt.phase     = PH_RST_HI;
        end
      end
      PH_START: begin
        case (cur.bit_index)
          4'd0: begin
            nxt.sck = 1'b0;
            nxt.sda = 1'b1;
          end
          4'd1: nxt.sck = 1'b1;
          4'd2: nxt.sda = 1'b0;
          4'd3: nxt.sck = 1'b0;
          4'd4: nxt.sck = 1'b1;
          4'd5: nxt.sda = 1'b1;
          default: nxt.sck = 1'b0;
        endcase
        if (cur.bit_index >= START_LAST) begin
          if (cur.command_byte == CMD_NONE) begin
            nxt.phase = PH_IDLE;
            done      = 1'b1;
          end else begin
            nxt.phase     = PH_WR_SET;
            nxt.bit_index = 4'd7;
          end
        end else begin
          nxt.bit_index = cur.bit_index + 4'd1;
        end
      end
      PH_WR_SET: begin
        nxt.sda   = cur.command_byte[cur.bit_index[2:0]];
        nxt.phase = PH_WR_HI;
      end
      PH_WR_HI: begin
        nxt.sck   = 1'b1;
        nxt.phase = PH_WR_LO;
      end
      PH_WR_LO: begin
        nxt.sck = 1'b0;
        if (cur.bit_index == 4'd0) begin
          nxt.phase = PH_ACK_REL;
        end else begin
          nxt.bit_index = cur.bit_index - 4'd1;
          nxt.phase     = PH_WR_SET;
        end
      end
      PH_ACK_REL: begin
        nxt.sda   = 1'b1;
        nxt.phase = PH_ACK_HI;
      end
      PH_ACK_HI: begin
        nxt.sck = 1'b1;
        // sensor must pull data low to acknowledge
        if (din) begin
          nxt.fault_store = fault_inc;
        end
        nxt.phase = PH_ACK_LO;
      end
      PH_ACK_LO: begin
        nxt.sck        = 1'b0;
        nxt.sda        = 1'b1;
        nxt.wait_count = 16'd0;
        nxt.phase      = PH_WAIT;
      end
      PH_WAIT: begin
        if (!din) begin
          nxt.byte_index = 2'd0;
          nxt.phase      = PH_RD_REL;
        end else begin
          nxt.wait_count = wait_inc;
          // timeout: count a fault and read anyway
          if (wait_inc >= wait_limit) begin
            nxt.fault_store = fault_inc;
            nxt.byte_index  = 2'd0;
            nxt.phase       = PH_RD_REL;
          end
        end
      end
      PH_RD_REL: begin
        nxt.sda       = 1'b1;
        nxt.shift_reg = 8'd0;
        nxt.bit_index = 4'd7;
        nxt.phase     = PH_RD_HI;
      end
      PH_RD_HI: begin
        nxt.sck = 1'b1;
        if (din) begin
          nxt.shift_reg[cur.bit_index[2:0]] = 1'b1;
        end
        nxt.phase = PH_RD_LO;
      end
      PH_RD_LO: begin
        nxt.sck = 1'b0;
        if (cur.bit_index == 4'd0) begin
          nxt.phase = PH_RA_SET;
        end else begin
          nxt.bit_index = cur.bit_index - 4'd1;
          nxt.phase     = PH_RD_HI;
        end
      end
      PH_RA_SET: begin
        // store the byte, ack the value bytes, not the checksum
        if (cur.byte_index == 2'd0) begin
          nxt.value_store[15:8] = cur.shift_reg;
          nxt.sda               = 1'b0;
        end else if (cur.byte_index == 2'd1) begin
          nxt.value_store[7:0] = cur.shift_reg;
          nxt.sda              = 1'b0;
        end else begin
          nxt.checksum_store = cur.shift_reg;
          nxt.sda            = 1'b1;
        end
        nxt.phase = PH_RA_HI;
      end
      PH_RA_HI: begin
        nxt.sck   = 1'b1;
        nxt.phase = PH_RA_LO;
      end
      PH_RA_LO: begin
        nxt.sck   = 1'b0;
        nxt.phase = PH_RA_REL;
      end
      PH_RA_REL: begin
        nxt.sda = 1'b1;
        if (cur.byte_index >= 2'd2) begin
          nxt.phase = PH_IDLE;
          done      = 1'b1;
        end else begin
          nxt.byte_index = cur.byte_index + 2'd1;
          nxt.phase      = PH_RD_REL;
        end
      end
      default: begin
        nxt.phase = PH_IDLE;
        nxt.sck   = 1'b0;
        nxt.sda   = 1'b1;
      end
    endcase
  end
endmodule
`default_nettype wire

### hdl/two_wire_sensor_measure_master.sv
`default_nettype none
// Two-wire humidity/temperature sensor bus master. Each input word is one pin
// step: op starts a humidity or temperature measurement or a connection reset
// when the master is idle, and data_line is the sampled data pin. Every input
// word yields exactly one result word with the clock and data drive levels,
// busy and finished flags, the last 16-bit raw value, the checksum byte and
// the fault count (missing acknowledge plus wait timeout). One word is taken
// per clock: the step logic sits between the state registers and a single
// output register, and a new word is accepted whenever that register is empty
// or being emptied in the same cycle. wait_limit is written over the APB port
// at any address with paddr[2] clear (0 to 3).
module two_wire_sensor_measure_master (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  tws_in_if.sink                             in_chan,
  tws_out_if.source                          out_chan,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [tws_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]                   cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);
  import tws_pkg::*;

  apb_req_t    apb_req;
  logic [15:0] wait_limit;
  state_t      state_r;
  state_t      state_nxt;
  logic        step_done;
  logic        accept;
  logic        out_valid_r;
  logic        sck_r;
  logic        sda_r;
  logic        busy_r;
  logic        done_r;
  logic [15:0] raw_r;
  logic [7:0]  chk_r;
  logic [1:0]  fault_r;

  // configuration port
  assign apb_req.psel    = cfg_psel;
  assign apb_req.penable = cfg_penable;
  assign apb_req.pwrite  = cfg_pwrite;
  assign apb_req.paddr   = cfg_paddr;
  assign apb_req.pwdata  = cfg_pwdata;
  assign cfg_pready      = 1'b1;

  tws_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (apb_req),
    .prdata     (cfg_prdata),
    .wait_limit (wait_limit)
  );

  tws_step u_step (
    .cur        (state_r),
    .op         (in_chan.op),
    .din        (in_chan.data_line),
    .wait_limit (wait_limit),
    .nxt        (state_nxt),
    .done       (step_done)
  );

  // accept while the output register is free or draining
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  // bus master state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase          <= PH_IDLE;
      state_r.bit_index      <= 4'd0;
      state_r.byte_index     <= 2'd0;
      state_r.shift_reg      <= 8'd0;
      state_r.value_store    <= 16'd0;
      state_r.checksum_store <= 8'd0;
      state_r.wait_count     <= 16'd0;
      state_r.fault_store    <= 2'd0;
      state_r.command_byte   <= CMD_NONE;
      state_r.sck            <= 1'b0;
      state_r.sda            <= 1'b1;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      sck_r   <= state_nxt.sck;
      sda_r   <= state_nxt.sda;
      busy_r  <= (state_nxt.phase != PH_IDLE);
      done_r  <= step_done;
      raw_r   <= state_nxt.value_store;
      chk_r   <= state_nxt.checksum_store;
      fault_r <= state_nxt.fault_store;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.sck_level   = sck_r;
  assign out_chan.data_level  = sda_r;
  assign out_chan.busy_res    = busy_r;
  assign out_chan.finished    = done_r;
  assign out_chan.raw_value   = raw_r;
  assign out_chan.check_byte  = chk_r;
  assign out_chan.fault_count = fault_r;
endmodule
`default_nettype wire
